FILE: hdl/blru_pkg.sv
package blru_pkg;

    localparam int ENTRIES    = 32;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int KEY_W      = 32;
    localparam int BYTES_W    = 32;
    localparam int STAMP_W    = 64;
    localparam int KIND_W     = 3;
    localparam logic [BYTES_W-1:0] BUDGET_RST = BYTES_W'(67108864);

    typedef enum logic [KIND_W-1:0] {
        KIND_HIT    = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_BYPASS = 3'd2,
        KIND_FAIL   = 3'd3,
        KIND_EVICT  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    // table update command
    typedef struct packed {
        logic                ins;
        logic                stamp_wr;
        logic                evict;
        logic [IDX_W-1:0]    addr;
        logic [KEY_W-1:0]    key;
        logic [BYTES_W-1:0]  size;
        logic [STAMP_W-1:0]  stamp;
    } t_st_cmd;

    // outcome of one table pass
    typedef struct packed {
        logic                hit;
        logic [IDX_W-1:0]    hit_idx;
        logic [BYTES_W-1:0]  hit_size;
        logic                free;
        logic [IDX_W-1:0]    free_idx;
        logic                vic;
        logic [IDX_W-1:0]    vic_idx;
        logic [KEY_W-1:0]    vic_key;
        logic [BYTES_W-1:0]  vic_size;
    } t_scan_res;

endpackage

FILE: hdl/blru_if.sv
interface blru_req_if;
    logic                        valid;
    logic                        ready;
    logic [blru_pkg::KEY_W-1:0]   req_key;
    logic [blru_pkg::BYTES_W-1:0] obj_bytes;
    logic                        load_ok;

    modport source (output valid, output req_key, output obj_bytes, output load_ok,
                    input ready);
    modport sink (input valid, input req_key, input obj_bytes, input load_ok,
                  output ready);
endinterface

interface blru_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [blru_pkg::KIND_W-1:0]  kind;
    logic [blru_pkg::KEY_W-1:0]   entry_key;
    logic [blru_pkg::BYTES_W-1:0] entry_bytes;
    logic [blru_pkg::BYTES_W-1:0] bytes_in_use;
    logic                        last;

    modport source (output valid, output kind, output entry_key, output entry_bytes,
                    output bytes_in_use, output last, input ready);
    modport sink (input valid, input kind, input entry_key, input entry_bytes,
                  input bytes_in_use, input last, output ready);
endinterface

interface blru_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [blru_pkg::BYTES_W-1:0] byte_budget;

    modport source (output valid, output byte_budget, input ready);
    modport sink (input valid, input byte_budget, output ready);
endinterface

FILE: hdl/byte_budget_lru_cache_top.sv
// Channel   Dir  Handshake      Payload
// i_req     in   valid/ready    req_key, obj_bytes, load_ok
// o_rsp     out  valid/ready    kind, entry_key, entry_bytes, bytes_in_use, last
// i_cfg     in   valid/ready    byte_budget
//
// One table pass reads one entry per cycle through the scan unit; a hit, failed load,
// bypass or plain insert takes a single pass from accept.
// Each eviction costs one more pass; up to ENTRIES + 1 passes.
// Synchronous active-low reset clears valid bits, stamp counter and byte total
// and loads the budget with 64 MiB; no clearing pass.
// A stalled o_rsp holds the decide step; i_req.ready and i_cfg.ready are high only when idle.
module byte_budget_lru_cache_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    blru_req_if.sink   i_req,
    blru_rsp_if.source o_rsp,
    blru_cfg_if.sink   i_cfg
);

    blru_pkg::t_state              r_state;
    blru_pkg::t_state              n_state;
    logic [blru_pkg::KEY_W-1:0]    r_key;
    logic [blru_pkg::KEY_W-1:0]    n_key;
    logic [blru_pkg::BYTES_W-1:0]  r_size;
    logic [blru_pkg::BYTES_W-1:0]  n_size;
    logic                          r_ok;
    logic                          n_ok;
    logic [blru_pkg::BYTES_W-1:0]  r_budget;
    logic [blru_pkg::BYTES_W-1:0]  n_budget;
    logic [blru_pkg::BYTES_W-1:0]  r_used;
    logic [blru_pkg::BYTES_W-1:0]  n_used;
    logic [blru_pkg::STAMP_W-1:0]  r_stamp;
    logic [blru_pkg::STAMP_W-1:0]  n_stamp;
    logic                          r_ov;
    logic                          n_ov;
    blru_pkg::t_kind               r_kind;
    blru_pkg::t_kind               n_kind;
    logic [blru_pkg::KEY_W-1:0]    r_okey;
    logic [blru_pkg::KEY_W-1:0]    n_okey;
    logic [blru_pkg::BYTES_W-1:0]  r_obytes;
    logic [blru_pkg::BYTES_W-1:0]  n_obytes;
    logic [blru_pkg::BYTES_W-1:0]  r_oused;
    logic [blru_pkg::BYTES_W-1:0]  n_oused;
    logic                          r_last;
    logic                          n_last;

    blru_pkg::t_st_cmd             st_cmd;
    blru_pkg::t_scan_res           scan_res;
    logic                          scan_start;
    logic                          scan_done;
    logic [blru_pkg::IDX_W-1:0]    rd_addr;
    logic [blru_pkg::KEY_W-1:0]    rd_key;
    logic [blru_pkg::BYTES_W-1:0]  rd_size;
    logic [blru_pkg::STAMP_W-1:0]  rd_stamp;
    logic [blru_pkg::ENTRIES-1:0]  valid_vec;

    logic                          req_acc;
    logic                          cfg_acc;
    logic                          out_free;
    logic                          emit;
    logic                          fit_over;
    logic                          act_hit;
    logic                          act_fail;
    logic                          act_byp;
    logic                          act_evict;
    logic                          act_ins;
    logic [blru_pkg::STAMP_W-1:0]  stamp_inc;

    blru_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (st_cmd),
        .i_rd_addr  (rd_addr),
        .o_rd_key   (rd_key),
        .o_rd_size  (rd_size),
        .o_rd_stamp (rd_stamp),
        .o_valid    (valid_vec)
    );

    blru_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_start),
        .i_key      (r_key),
        .i_valid    (valid_vec),
        .i_rd_key   (rd_key),
        .i_rd_size  (rd_size),
        .i_rd_stamp (rd_stamp),
        .o_rd_addr  (rd_addr),
        .o_done     (scan_done),
        .o_res      (scan_res)
    );

    assign i_req.ready = (r_state == blru_pkg::ST_IDLE);
    assign i_cfg.ready = (r_state == blru_pkg::ST_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign out_free    = !r_ov || o_rsp.ready;
    assign emit        = (r_state == blru_pkg::ST_DECIDE) && out_free;
    assign stamp_inc   = r_stamp + blru_pkg::STAMP_W'(1);

    assign fit_over  = ({1'b0, r_used} + {1'b0, r_size}) > {1'b0, r_budget};
    assign act_hit   = scan_res.hit;
    assign act_fail  = !scan_res.hit && !r_ok;
    assign act_byp   = !scan_res.hit && r_ok && (r_size > r_budget);
    assign act_evict = !scan_res.hit && r_ok && !act_byp &&
                       ((fit_over && scan_res.vic) || !scan_res.free);
    assign act_ins   = !scan_res.hit && r_ok && !act_byp && !act_evict;

    always_comb begin
        n_state = r_state;
        case (r_state)
            blru_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_state = blru_pkg::ST_SCAN;
                end
            end
            blru_pkg::ST_SCAN: begin
                if (scan_done) begin
                    n_state = blru_pkg::ST_DECIDE;
                end
            end
            blru_pkg::ST_DECIDE: begin
                if (out_free) begin
                    n_state = act_evict ? blru_pkg::ST_SCAN : blru_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = blru_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_key      = r_key;
        n_size     = r_size;
        n_ok       = r_ok;
        n_budget   = r_budget;
        n_used     = r_used;
        n_stamp    = r_stamp;
        n_ov       = r_ov && !o_rsp.ready;
        n_kind     = r_kind;
        n_okey     = r_okey;
        n_obytes   = r_obytes;
        n_oused    = r_oused;
        n_last     = r_last;
        st_cmd     = '0;
        scan_start = 1'b0;
        if (cfg_acc) begin
            n_budget = i_cfg.byte_budget;
        end
        case (r_state)
            blru_pkg::ST_IDLE: begin
                if (req_acc) begin
                    n_key      = i_req.req_key;
                    n_size     = i_req.obj_bytes;
                    n_ok       = i_req.load_ok;
                    scan_start = 1'b1;
                end
            end
            blru_pkg::ST_DECIDE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_okey  = r_key;
                    n_last  = 1'b1;
                    n_oused = r_used;
                    if (act_hit) begin
                        n_kind          = blru_pkg::KIND_HIT;
                        n_obytes        = scan_res.hit_size;
                        n_stamp         = stamp_inc;
                        st_cmd.stamp_wr = 1'b1;
                        st_cmd.addr     = scan_res.hit_idx;
                        st_cmd.stamp    = stamp_inc;
                    end else if (act_fail) begin
                        n_kind   = blru_pkg::KIND_FAIL;
                        n_obytes = '0;
                    end else if (act_byp) begin
                        n_kind   = blru_pkg::KIND_BYPASS;
                        n_obytes = r_size;
                    end else if (act_evict) begin
                        n_kind       = blru_pkg::KIND_EVICT;
                        n_okey       = scan_res.vic_key;
                        n_obytes     = scan_res.vic_size;
                        n_used       = r_used - scan_res.vic_size;
                        n_oused      = r_used - scan_res.vic_size;
                        n_last       = 1'b0;
                        st_cmd.evict = 1'b1;
                        st_cmd.addr  = scan_res.vic_idx;
                        scan_start   = 1'b1;
                    end else begin
                        n_kind       = blru_pkg::KIND_INSERT;
                        n_obytes     = r_size;
                        n_used       = r_used + r_size;
                        n_oused      = r_used + r_size;
                        n_stamp      = stamp_inc;
                        st_cmd.ins   = 1'b1;
                        st_cmd.addr  = scan_res.free_idx;
                        st_cmd.key   = r_key;
                        st_cmd.size  = r_size;
                        st_cmd.stamp = stamp_inc;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= blru_pkg::ST_IDLE;
            r_budget <= blru_pkg::BUDGET_RST;
            r_used   <= '0;
            r_stamp  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_budget <= n_budget;
            r_used   <= n_used;
            r_stamp  <= n_stamp;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_size   <= n_size;
        r_ok     <= n_ok;
        r_kind   <= n_kind;
        r_okey   <= n_okey;
        r_obytes <= n_obytes;
        r_oused  <= n_oused;
        r_last   <= n_last;
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.kind         = r_kind;
    assign o_rsp.entry_key    = r_okey;
    assign o_rsp.entry_bytes  = r_obytes;
    assign o_rsp.bytes_in_use = r_oused;
    assign o_rsp.last         = r_last;

    a_evict_has_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && act_evict |-> scan_res.vic)
        else $error("eviction without a valid victim");

    a_insert_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && act_ins |-> scan_res.free && !valid_vec[scan_res.free_idx])
        else $error("insert into an occupied slot");

    a_insert_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && act_ins |=> r_used <= r_budget)
        else $error("byte total above budget after insert");

    a_open_is_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !r_last |-> r_kind == blru_pkg::KIND_EVICT)
        else $error("non-final transaction that is not an eviction");

endmodule

FILE: hdl/blru_store.sv
module blru_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  blru_pkg::t_st_cmd                 i_cmd,
    input  logic [blru_pkg::IDX_W-1:0]        i_rd_addr,
    output logic [blru_pkg::KEY_W-1:0]        o_rd_key,
    output logic [blru_pkg::BYTES_W-1:0]      o_rd_size,
    output logic [blru_pkg::STAMP_W-1:0]      o_rd_stamp,
    output logic [blru_pkg::ENTRIES-1:0]      o_valid
);

    logic [blru_pkg::KEY_W-1:0]   r_key_mem   [blru_pkg::ENTRIES];
    logic [blru_pkg::BYTES_W-1:0] r_size_mem  [blru_pkg::ENTRIES];
    logic [blru_pkg::STAMP_W-1:0] r_stamp_mem [blru_pkg::ENTRIES];
    logic [blru_pkg::KEY_W-1:0]   r_rd_key;
    logic [blru_pkg::BYTES_W-1:0] r_rd_size;
    logic [blru_pkg::STAMP_W-1:0] r_rd_stamp;
    logic [blru_pkg::ENTRIES-1:0] r_valid;
    logic [blru_pkg::ENTRIES-1:0] n_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            r_key_mem[i_cmd.addr]  <= i_cmd.key;
            r_size_mem[i_cmd.addr] <= i_cmd.size;
        end
        if (i_cmd.ins || i_cmd.stamp_wr) begin
            r_stamp_mem[i_cmd.addr] <= i_cmd.stamp;
        end
        r_rd_key   <= r_key_mem[i_rd_addr];
        r_rd_size  <= r_size_mem[i_rd_addr];
        r_rd_stamp <= r_stamp_mem[i_rd_addr];
    end

    always_comb begin
        n_valid = r_valid;
        if (i_cmd.ins) begin
            n_valid[i_cmd.addr] = 1'b1;
        end
        if (i_cmd.evict) begin
            n_valid[i_cmd.addr] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_size  = r_rd_size;
    assign o_rd_stamp = r_rd_stamp;
    assign o_valid    = r_valid;

endmodule

FILE: hdl/blru_scan.sv
module blru_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [blru_pkg::KEY_W-1:0]        i_key,
    input  logic [blru_pkg::ENTRIES-1:0]      i_valid,
    input  logic [blru_pkg::KEY_W-1:0]        i_rd_key,
    input  logic [blru_pkg::BYTES_W-1:0]      i_rd_size,
    input  logic [blru_pkg::STAMP_W-1:0]      i_rd_stamp,
    output logic [blru_pkg::IDX_W-1:0]        o_rd_addr,
    output logic                              o_done,
    output blru_pkg::t_scan_res               o_res
);

    localparam logic [blru_pkg::IDX_W-1:0] LAST_IDX = blru_pkg::IDX_W'(blru_pkg::ENTRIES - 1);

    logic                         r_busy;
    logic                         n_busy;
    logic [blru_pkg::IDX_W-1:0]   r_addr;
    logic [blru_pkg::IDX_W-1:0]   n_addr;
    logic                         r_eval;
    logic [blru_pkg::IDX_W-1:0]   r_eval_idx;
    logic                         r_done;
    blru_pkg::t_scan_res          r_res;
    blru_pkg::t_scan_res          n_res;
    logic [blru_pkg::STAMP_W-1:0] r_vic_stamp;
    logic [blru_pkg::STAMP_W-1:0] n_vic_stamp;
    logic                         eval_v;
    logic                         key_eq;
    logic                         stamp_lt;

    assign eval_v   = i_valid[r_eval_idx];
    assign key_eq   = (i_rd_key == i_key);
    assign stamp_lt = (i_rd_stamp < r_vic_stamp);

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        if (i_start) begin
            n_busy = 1'b1;
            n_addr = '0;
        end else if (r_busy) begin
            n_addr = r_addr + blru_pkg::IDX_W'(1);
            if (r_addr == LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
    end

    always_comb begin
        n_res       = r_res;
        n_vic_stamp = r_vic_stamp;
        if (i_start) begin
            n_res.hit  = 1'b0;
            n_res.free = 1'b0;
            n_res.vic  = 1'b0;
        end else if (r_eval) begin
            if (eval_v && key_eq && !r_res.hit) begin
                n_res.hit      = 1'b1;
                n_res.hit_idx  = r_eval_idx;
                n_res.hit_size = i_rd_size;
            end
            if (!eval_v && !r_res.free) begin
                n_res.free     = 1'b1;
                n_res.free_idx = r_eval_idx;
            end
            // strict less-than keeps the lowest slot on equal stamps
            if (eval_v && (!r_res.vic || stamp_lt)) begin
                n_res.vic      = 1'b1;
                n_res.vic_idx  = r_eval_idx;
                n_res.vic_key  = i_rd_key;
                n_res.vic_size = i_rd_size;
                n_vic_stamp    = i_rd_stamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_eval <= 1'b0;
            r_done <= 1'b0;
            r_res  <= '0;
        end else begin
            r_busy <= n_busy;
            r_eval <= r_busy && !i_start;
            r_done <= r_eval && !i_start && (r_eval_idx == LAST_IDX);
            r_res  <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_eval_idx  <= r_addr;
        r_vic_stamp <= n_vic_stamp;
    end

    assign o_rd_addr = r_addr;
    assign o_done    = r_done;
    assign o_res     = r_res;

endmodule
